// ===== rtl/core/first_fit_free_list_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit allocator
// Concurrent checks, compiled away when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// check held while out of reset
`define FFA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("allocator check failed");
// check held on every edge, reset included
`define FFA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("allocator check failed");
`else
`define FFA_ASSERT(lbl, clk, rst_n, prop)
`define FFA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/core/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants and types of the first-fit free-list allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int SLAB_BYTES   = 4096;
    localparam int MAX_SEGMENTS = 32;
    localparam int MAX_RECORDS  = 32;

    localparam int SEG_W    = 17;
    localparam int MAX_STEP = ((MAX_SEGMENTS > MAX_RECORDS) ? MAX_SEGMENTS : MAX_RECORDS) + 1;
    localparam int STEP_W   = $clog2(MAX_STEP + 1);
    localparam int REC_AW   = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;

    localparam logic [2:0] STAT_OK    = 3'd0;
    localparam logic [2:0] STAT_SMALL = 3'd1;
    localparam logic [2:0] STAT_NOFIT = 3'd2;
    localparam logic [2:0] STAT_BOUND = 3'd3;
    localparam logic [2:0] STAT_FULL  = 3'd4;

    typedef struct packed {
        logic [SEG_W-1:0] off;
        logic [SEG_W-1:0] len;
    } t_seg;

    typedef struct packed {
        logic shift;
    } t_ring_ctl;

endpackage

// ===== rtl/core/first_fit_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator
// First-fit heap allocator with coalescing free list held in a cell ring.
// ----------------------------------------------------------------------------
// Sequence: a request is accepted in idle, scanned over the segment ring and
//   record table, decided, then, when it changes the list, applied in an
//   update pass over the ring before the result is registered.
// Throughput: one request at a time; the next is accepted once the result is
//   loaded into the output register; a stalled result holds it off.
// Reset (sync, active low): ring holds one segment covering the slab, no
//   allocation records valid, slab_base 0. No clearing pass is needed.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config: slab_base
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [31:0]                      i_cfg_data,
    // request stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [ffa_pkg::IN_DATA_W-1:0]    i_s_tdata,  // req_size[15:0], free_address[47:16]
    input  logic [0:0]                       i_s_tuser,  // op[0]: 0 allocate, 1 free
    // result stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [ffa_pkg::OUT_DATA_W-1:0]   o_m_tdata   // result_address[31:0], status[34:32]
);
    import ffa_pkg::*;

    `include "first_fit_free_list_allocator_defines.svh"

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_APPLY  = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    // list edit applied during the update pass
    localparam logic [2:0] MD_ALLOC = 3'd0;
    localparam logic [2:0] MD_BOTH  = 3'd1;
    localparam logic [2:0] MD_PREV  = 3'd2;
    localparam logic [2:0] MD_NEXT  = 3'd3;
    localparam logic [2:0] MD_INS   = 3'd4;

    localparam logic [STEP_W-1:0] SCAN_LAST = STEP_W'(MAX_STEP - 1);
    localparam logic [STEP_W-1:0] NSEG      = STEP_W'(MAX_SEGMENTS);
    localparam logic [STEP_W-1:0] NREC      = STEP_W'(MAX_RECORDS);
    localparam logic [STEP_W-1:0] APPLY_LAST = STEP_W'(MAX_SEGMENTS - 1);

    logic [2:0]        r_state;
    logic [31:0]       r_slab_base;
    logic [STEP_W-1:0] r_cnt;
    logic [STEP_W-1:0] r_count;

    // request
    logic              r_op;
    logic [15:0]       r_size;
    logic [SEG_W-1:0]  r_off;
    logic              r_off_ok;

    // segment scan results
    logic              r_found;
    logic [STEP_W-1:0] r_fi;
    t_seg              r_fseg;
    logic [STEP_W-1:0] r_p;
    t_seg              r_pseg;
    logic              r_brk;
    t_seg              r_qseg;

    // record scan
    logic [MAX_RECORDS-1:0] r_rec_valid;
    logic              r_rd_act;
    logic              r_rv;
    logic [REC_AW-1:0] r_ridx;
    logic              r_slot_ok;
    logic              r_hit;
    logic [REC_AW-1:0] r_slot;
    logic [SEG_W-1:0]  r_hlen;
    t_seg              w_rec_rd;

    // decision
    logic [2:0]        r_mode;
    logic [2:0]        r_status;
    logic [31:0]       r_addr;
    logic [SEG_W-1:0]  r_mlen;
    logic [SEG_W-1:0]  r_nlen;
    t_seg              r_carry;

    // output register
    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;

    // ring
    t_ring_ctl w_ctl;
    t_seg      w_ring_q [MAX_SEGMENTS];
    t_seg      w_push;
    t_seg      w_head;

    // record RAM write
    logic              w_rec_we;
    t_seg              w_rec_wd;

    // decide-cycle terms
    logic [SEG_W-1:0]  w_need;
    logic [SEG_W:0]    w_need8;
    logic              w_mn;
    logic              w_mp;
    logic [SEG_W:0]    w_newlen;
    logic [SEG_W+1:0]  w_end;
    logic              w_succ;
    logic [SEG_W-1:0]  w_roff;
    logic [STEP_W-1:0] w_q;
    logic [31:0]       w_off32;

    assign w_head  = w_ring_q[0];
    assign w_need  = SEG_W'(r_size) + SEG_W'(4);
    assign w_need8 = (SEG_W+1)'(w_need) + (SEG_W+1)'(8);
    assign w_q     = r_p + STEP_W'(1);
    assign w_off32 = i_s_tdata[47:16] - r_slab_base - 32'd4;

    // free-side merge tests; the successor exists only when the scan broke
    assign w_mn = r_brk && ({1'b0, r_qseg.off} == ({1'b0, r_off} + {1'b0, r_hlen}));
    assign w_mp = ({1'b0, r_pseg.off} + {1'b0, r_pseg.len}) == {1'b0, r_off};
    assign w_newlen = {1'b0, r_hlen} + (w_mn ? {1'b0, r_qseg.len} : '0);
    assign w_succ   = w_mn ? ((w_q + STEP_W'(1)) < r_count) : r_brk;
    assign w_end    = {2'b0, r_off} + {1'b0, w_newlen};
    assign w_roff   = r_fseg.off + (r_fseg.len - w_need);

    assign w_rec_we = (r_state == ST_DECIDE) && !r_op && (r_size >= 16'd4) && r_found
                      && r_slot_ok;
    assign w_rec_wd = '{off: w_roff, len: w_need};

    ffa_ram #(
        .WIDTH (2 * SEG_W),
        .DEPTH (MAX_RECORDS)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (w_rec_we),
        .i_waddr (r_slot),
        .i_wdata (w_rec_wd),
        .i_raddr (r_cnt[REC_AW-1:0]),
        .o_rdata (w_rec_rd)
    );

    // ring shifts during both passes, one cell per cycle
    assign w_ctl.shift = ((r_state == ST_SCAN) && (r_cnt < NSEG)) || (r_state == ST_APPLY);

    // value fed back into the tail; plain rotation unless the update pass edits
    always_comb begin
        w_push = w_head;
        if (r_state == ST_APPLY) begin
            unique case (r_mode)
                MD_ALLOC: begin
                    if (r_cnt == r_fi) begin
                        w_push = '{off: w_head.off, len: r_fseg.len - w_need};
                    end
                end
                MD_PREV: begin
                    if (r_cnt == r_p) begin
                        w_push = '{off: w_head.off, len: r_mlen};
                    end
                end
                MD_NEXT: begin
                    if (r_cnt == w_q) begin
                        w_push = '{off: r_off, len: r_nlen};
                    end
                end
                MD_BOTH: begin
                    // successor drops out: later entries move up by one
                    if (r_cnt == r_p) begin
                        w_push = '{off: w_head.off, len: r_mlen};
                    end else if (r_cnt >= w_q) begin
                        w_push = w_ring_q[1];
                    end
                end
                MD_INS: begin
                    // new segment goes in, the rest trail one slot behind
                    if (r_cnt == w_q) begin
                        w_push = '{off: r_off, len: r_hlen};
                    end else if (r_cnt > w_q) begin
                        w_push = r_carry;
                    end
                end
                default: w_push = w_head;
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
            t_seg w_init;
            t_seg w_d;
            if (g == 0) begin : g_first
                assign w_init = '{off: '0, len: SEG_W'(SLAB_BYTES)};
            end else begin : g_rest
                assign w_init = '0;
            end
            if (g == MAX_SEGMENTS - 1) begin : g_tail
                assign w_d = w_push;
            end else begin : g_mid
                assign w_d = w_ring_q[g+1];
            end
            ffa_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_init  (w_init),
                .i_d     (w_d),
                .o_q     (w_ring_q[g])
            );
        end
    endgenerate

    // config port: writes land only while idle, between requests
    assign o_cfg_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slab_base <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_slab_base <= i_cfg_data;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // control path
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_count     <= STEP_W'(1);
            r_rec_valid <= '0;
            r_rd_act    <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            if ((r_state == ST_DONE) && (!r_m_valid || i_m_tready)) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state  <= ST_SCAN;
                        r_cnt    <= '0;
                        r_rd_act <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    r_rd_act <= (r_cnt < NREC);
                    if (r_cnt == SCAN_LAST) begin
                        r_state <= ST_DECIDE;
                    end else begin
                        r_cnt <= r_cnt + STEP_W'(1);
                    end
                end
                ST_DECIDE: begin
                    r_cnt <= '0;
                    if (!r_op && (r_size >= 16'd4) && r_found && r_slot_ok) begin
                        r_rec_valid[r_slot] <= 1'b1;
                        r_state             <= ST_APPLY;
                    end else if (r_op && r_hit && !(!w_mn && !w_mp && (r_count >= NSEG))) begin
                        r_rec_valid[r_slot] <= 1'b0;
                        r_state             <= ST_APPLY;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_APPLY: begin
                    if (r_cnt == APPLY_LAST) begin
                        r_state <= ST_DONE;
                        if (r_mode == MD_BOTH) begin
                            r_count <= r_count - STEP_W'(1);
                        end else if (r_mode == MD_INS) begin
                            r_count <= r_count + STEP_W'(1);
                        end
                    end else begin
                        r_cnt <= r_cnt + STEP_W'(1);
                    end
                end
                ST_DONE: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // data path
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_s_tvalid) begin
            r_op      <= i_s_tuser[0];
            r_size    <= i_s_tdata[15:0];
            r_off     <= w_off32[SEG_W-1:0];
            r_off_ok  <= (w_off32[31:SEG_W] == '0);
            r_found   <= 1'b0;
            r_fi      <= '0;
            r_p       <= '0;
            r_pseg    <= w_head;
            r_brk     <= 1'b0;
            r_slot_ok <= 1'b0;
            r_hit     <= 1'b0;
        end

        if (r_state == ST_SCAN) begin
            r_rv   <= r_rec_valid[r_cnt[REC_AW-1:0]];
            r_ridx <= r_cnt[REC_AW-1:0];
            // segment under the head has index r_cnt
            if ((r_cnt < NSEG) && (r_cnt < r_count)) begin
                if (!r_found && ({1'b0, w_head.len} >= w_need8)) begin
                    r_found <= 1'b1;
                    r_fi    <= r_cnt;
                    r_fseg  <= w_head;
                end
                if (!r_brk) begin
                    if (w_head.off <= r_off) begin
                        r_p    <= r_cnt;
                        r_pseg <= w_head;
                    end else begin
                        r_brk  <= 1'b1;
                        r_qseg <= w_head;
                    end
                end
            end
            // record read issued last cycle
            if (r_rd_act) begin
                if (!r_slot_ok && !r_rv) begin
                    r_slot_ok <= 1'b1;
                    if (!r_op) begin
                        r_slot <= r_ridx;
                    end
                end
                if (!r_hit && r_rv && r_off_ok && (w_rec_rd.off == r_off)) begin
                    r_hit  <= 1'b1;
                    r_hlen <= w_rec_rd.len;
                    if (r_op) begin
                        r_slot <= r_ridx;
                    end
                end
            end
        end

        if (r_state == ST_DECIDE) begin
            r_nlen <= w_newlen[SEG_W-1:0];
            r_mlen <= (w_mp && w_mn) ? (r_pseg.len + w_newlen[SEG_W-1:0])
                                     : (r_pseg.len + r_hlen);
            if (!r_op) begin
                r_mode <= MD_ALLOC;
                if (r_size < 16'd4) begin
                    r_status <= STAT_SMALL;
                    r_addr   <= '0;
                end else if (!r_found) begin
                    r_status <= STAT_NOFIT;
                    r_addr   <= '0;
                end else if (!r_slot_ok) begin
                    r_status <= STAT_FULL;
                    r_addr   <= '0;
                end else begin
                    r_status <= STAT_OK;
                    r_addr   <= r_slab_base + 32'(w_roff) + 32'd4;
                end
            end else begin
                r_addr <= '0;
                if (w_mp && w_mn) begin
                    r_mode <= MD_BOTH;
                end else if (w_mp) begin
                    r_mode <= MD_PREV;
                end else if (w_mn) begin
                    r_mode <= MD_NEXT;
                end else begin
                    r_mode <= MD_INS;
                end
                if (!r_hit || (!w_mn && !w_mp && (r_count >= NSEG))) begin
                    r_status <= STAT_FULL;
                end else if ((w_end > (SEG_W+2)'(SLAB_BYTES))
                             || ((w_end == (SEG_W+2)'(SLAB_BYTES)) && w_succ)) begin
                    r_status <= STAT_BOUND;
                end else begin
                    r_status <= STAT_OK;
                end
            end
        end

        if (r_state == ST_APPLY) begin
            r_carry <= w_head;
        end

        if (r_state == ST_DONE && (!r_m_valid || i_m_tready)) begin
            r_m_data <= {5'b0, r_status, r_addr};
        end
    end

    // checks
    `FFA_ASSERT(a_count_range, i_clk, i_rst_n,
        (r_count >= STEP_W'(1)) && (r_count <= NSEG))
    `FFA_ASSERT(a_head_at_zero, i_clk, i_rst_n,
        (r_state == ST_IDLE) |-> (w_head.off == '0))
    `FFA_ASSERT(a_count_only_on_apply, i_clk, i_rst_n,
        (r_state == ST_DECIDE) |=> (r_count == $past(r_count)))
    `FFA_ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> ((r_rec_valid == '0) && (r_count == STEP_W'(1))))

endmodule

// ===== rtl/core/ffa_ram.sv =====
// ----------------------------------------------------------------------------
// ffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/ffa_cell.sv =====
// ----------------------------------------------------------------------------
// ffa_cell
// One free-segment slot of the rotating segment ring.
// ----------------------------------------------------------------------------
module ffa_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ffa_pkg::t_ring_ctl i_ctl,
    input  ffa_pkg::t_seg     i_init,
    input  ffa_pkg::t_seg     i_d,
    output ffa_pkg::t_seg     o_q
);
    import ffa_pkg::*;

    t_seg r_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg <= i_init;
        end else if (i_ctl.shift) begin
            r_seg <= i_d;
        end
    end

    assign o_q = r_seg;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: first-fit allocator regression
// Drives allocate/free requests with bursty gaps against a back-pressured
// result stream, predicts each response from a local free-list model and
// checks address and status in order.
// ----------------------------------------------------------------------------

// Request log and free-list model; holds expected responses in order.
class alloc_scoreboard;
    logic [31:0] base;
    logic [16:0] seg_off [ffa_pkg::MAX_SEGMENTS];
    logic [16:0] seg_len [ffa_pkg::MAX_SEGMENTS];
    int          seg_cnt;
    logic [16:0] rec_off [ffa_pkg::MAX_RECORDS];
    logic [16:0] rec_len [ffa_pkg::MAX_RECORDS];
    bit          rec_vld [ffa_pkg::MAX_RECORDS];
    logic [31:0] exp_addr [$];
    logic [2:0]  exp_stat [$];
    logic [31:0] live_addr [$];   // addresses currently handed out
    int          errors;

    function new();
        base = '0;
        seg_cnt = 1;
        errors = 0;
        foreach (seg_off[i]) begin
            seg_off[i] = '0;
            seg_len[i] = '0;
        end
        seg_len[0] = 17'(ffa_pkg::SLAB_BYTES);
        foreach (rec_vld[i]) begin
            rec_vld[i] = 0;
            rec_off[i] = '0;
            rec_len[i] = '0;
        end
    endfunction

    function automatic logic [2:0] allocate(input logic [15:0] size, output logic [31:0] a);
        int i;
        int r;
        int slot;
        logic [16:0] need;
        a = '0;
        slot = -1;
        if (size < 4) return ffa_pkg::STAT_SMALL;
        need = size + 17'd4;
        for (i = 0; i < seg_cnt; i++)
            if ({1'b0, seg_len[i]} >= {1'b0, need} + 18'd8) break;
        if (i == seg_cnt) return ffa_pkg::STAT_NOFIT;
        for (r = 0; r < ffa_pkg::MAX_RECORDS; r++)
            if (!rec_vld[r]) begin
                slot = r;
                break;
            end
        if (slot < 0) return ffa_pkg::STAT_FULL;
        seg_len[i] -= need;
        rec_off[slot] = seg_off[i] + seg_len[i];
        rec_len[slot] = need;
        rec_vld[slot] = 1;
        a = base + {15'd0, rec_off[slot]} + 32'd4;
        return ffa_pkg::STAT_OK;
    endfunction

    function automatic logic [2:0] release_block(input logic [31:0] address);
        logic [31:0] off;
        logic [31:0] len;
        logic [31:0] nlen;
        logic [31:0] fin;
        int i;
        int r;
        int p;
        int q;
        int slot;
        bit mn;
        bit mp;
        bit succ;
        logic [2:0] st;
        off = address - base - 32'd4;
        slot = -1;
        p = 0;
        st = ffa_pkg::STAT_OK;
        for (r = 0; r < ffa_pkg::MAX_RECORDS; r++)
            if (rec_vld[r] && {15'd0, rec_off[r]} == off) begin
                slot = r;
                break;
            end
        if (slot < 0) return ffa_pkg::STAT_FULL;
        len = {15'd0, rec_len[slot]};
        for (i = 0; i < seg_cnt; i++)
            if ({15'd0, seg_off[i]} <= off) p = i;
            else break;
        q = p + 1;
        mn = q < seg_cnt && {15'd0, seg_off[q]} == off + len;
        mp = {15'd0, seg_off[p]} + {15'd0, seg_len[p]} == off;
        if (!mn && !mp && seg_cnt >= ffa_pkg::MAX_SEGMENTS) return ffa_pkg::STAT_FULL;
        nlen = len + (mn ? {15'd0, seg_len[q]} : 32'd0);
        succ = mn ? (q + 1 < seg_cnt) : (q < seg_cnt);
        fin = off + nlen;
        if (fin > ffa_pkg::SLAB_BYTES || (fin == ffa_pkg::SLAB_BYTES && succ))
            st = ffa_pkg::STAT_BOUND;
        if (mp && mn) begin
            seg_len[p] = seg_len[p] + nlen[16:0];
            for (i = q; i + 1 < seg_cnt; i++) begin
                seg_off[i] = seg_off[i+1];
                seg_len[i] = seg_len[i+1];
            end
            seg_cnt--;
        end else if (mp) begin
            seg_len[p] = seg_len[p] + len[16:0];
        end else if (mn) begin
            seg_off[q] = off[16:0];
            seg_len[q] = nlen[16:0];
        end else begin
            for (i = seg_cnt; i > q; i--) begin
                seg_off[i] = seg_off[i-1];
                seg_len[i] = seg_len[i-1];
            end
            seg_off[q] = off[16:0];
            seg_len[q] = len[16:0];
            seg_cnt++;
        end
        rec_vld[slot] = 0;
        return st;
    endfunction

    // note an accepted request and queue its expected response
    function void note_request(input bit op, input logic [15:0] size, input logic [31:0] fa);
        logic [31:0] a;
        logic [2:0]  st;
        a = '0;
        if (!op) begin
            st = allocate(size, a);
            if (st == ffa_pkg::STAT_OK) live_addr.push_back(a);
        end else begin
            st = release_block(fa);
            foreach (live_addr[i])
                if (live_addr[i] == fa && st != ffa_pkg::STAT_FULL) begin
                    live_addr.delete(i);
                    break;
                end
        end
        exp_addr.push_back((st == ffa_pkg::STAT_OK && !op) ? a : 32'd0);
        exp_stat.push_back(st);
    endfunction

    function void check_response(input logic [31:0] a, input logic [2:0] st);
        logic [31:0] ea;
        logic [2:0]  es;
        if (exp_addr.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response addr=%h status=%0d", a, st);
            return;
        end
        ea = exp_addr.pop_front();
        es = exp_stat.pop_front();
        if (a !== ea || st !== es) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: addr exp %h got %h, status exp %0d got %0d", ea, a, es, st);
        end
    endfunction
endclass

module tb_top;
    import ffa_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;   // req_size[15:0], free_address[47:16]
    logic [0:0]  i_s_tuser;             // op
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;   // result_address[31:0], status[34:32]

    alloc_scoreboard sb;
    int  idle_cycles;
    bit  stall_on;
    int  stall_mode;
    bit  timed_out;

    first_fit_free_list_allocator dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // sample responses and watch for a hung block at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) sb.check_response(o_m_tdata[31:0], o_m_tdata[34:32]);
            if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready)
                    || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver back-pressure: mode changes per phase of the run
    always @(negedge i_clk) begin
        case (stall_mode)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= ($urandom_range(0, 3) != 0);
            default: begin
                if ($urandom_range(0, 15) == 0) stall_on = !stall_on;
                i_m_tready <= !stall_on;
            end
        endcase
    end

    // valid stays high after acceptance; the next request or a gap replaces it
    task automatic send_request(input bit op, input logic [15:0] size, input logic [31:0] fa);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {fa, size};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_request(op, size, fa);
        @(negedge i_clk);
    endtask

    // random gap between bursts; zero often so back-to-back requests occur
    task automatic burst_gap(inout int left);
        int n;
        if (left > 0) begin
            left--;
            return;
        end
        left = $urandom_range(1, 12);
        n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 80);
        if (n > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // wait until every outstanding response has been checked, then idle on
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.exp_addr.size() != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    task automatic write_base(input logic [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.base = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int count);
        int left;
        int k;
        logic [15:0] sz;
        logic [31:0] fa;
        left = 0;
        for (k = 0; k < count; k++) begin
            burst_gap(left);
            if ($urandom_range(0, 99) < 50 || sb.live_addr.size() == 0) begin
                case ($urandom_range(0, 9))
                    0:       sz = 16'($urandom);
                    1:       sz = 16'($urandom_range(0, 5));
                    2:       sz = 16'($urandom_range(200, 1200));
                    default: sz = 16'($urandom_range(4, 120));
                endcase
                send_request(1'b0, sz, $urandom);
            end else begin
                case ($urandom_range(0, 9))
                    0:       fa = $urandom;
                    1:       fa = sb.base + $urandom_range(0, 4200);
                    default: fa = sb.live_addr[$urandom_range(0, sb.live_addr.size() - 1)];
                endcase
                send_request(1'b1, 16'($urandom), fa);
            end
        end
    endtask

    initial begin
        int k;
        logic [31:0] a0;
        sb          = new();
        idle_cycles = 0;
        stall_on    = 0;
        stall_mode  = 0;
        timed_out   = 0;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        fork
            begin
                // directed: small sizes, extremes, frees, double free, bad address
                send_request(1'b0, 16'd0, 32'hFFFF_FFFF);
                send_request(1'b0, 16'd3, '0);
                send_request(1'b0, 16'hFFFF, '0);
                send_request(1'b0, 16'd4084, '0);
                send_request(1'b0, 16'd4, '0);
                a0 = sb.live_addr.size() ? sb.live_addr[0] : 32'd0;
                send_request(1'b0, 16'd16, '0);
                send_request(1'b0, 16'd16, '0);
                send_request(1'b1, '0, a0);
                send_request(1'b1, 16'hFFFF, a0);        // freed twice
                send_request(1'b1, '0, 32'hFFFF_FFFF);
                send_request(1'b1, '0, 32'd0);
                while (sb.live_addr.size() != 0)
                    send_request(1'b1, '0, sb.live_addr[sb.live_addr.size() - 1]);
                // fill the record table, then one more
                for (k = 0; k < MAX_RECORDS + 1; k++) send_request(1'b0, 16'd8, '0);
                // free every other block so the segment table grows
                for (k = 0; k < sb.live_addr.size(); k++)
                    send_request(1'b1, '0, sb.live_addr[k]);
                drain();

                write_base(32'hFFFF_FFF0);
                stall_mode = 1;
                random_phase(300);
                drain();
                write_base($urandom);
                stall_mode = 2;
                random_phase(300);
                drain();
                write_base(32'h0000_0000);
                stall_mode = 0;
                random_phase(300);
                drain();
            end
            begin
                while (idle_cycles < IDLE_LIMIT) @(negedge i_clk);
                timed_out = 1;
            end
        join_any

        if (timed_out) begin
            $display("Regression FAIL");
        end else if (sb.errors == 0 && sb.exp_addr.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
